@@ src/crse_pkg.sv @@
// shared constants for the catmull-rom segment evaluator
// no dependencies; imported by catmull_rom_segment_eval_top
`default_nettype none

package crse_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int T_FRAC_BITS_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 8;

  localparam int NUM_CP         = 4;
  localparam int NUM_AXES       = 3;
  localparam int CP_REG_BITS    = 48;
  localparam int CFG_DATA_WIDTH = 64;
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int CFG_IDX_LSB    = 3;
  localparam int CFG_IDX_WIDTH  = CFG_ADDR_WIDTH - CFG_IDX_LSB;

  localparam int OUT_WIDTH   = 32;
  localparam int PIPE_STAGES = 8;

endpackage

`default_nettype wire

@@ src/catmull_rom_segment_eval_top.sv @@
// uniform catmull-rom segment evaluator, 3d: position, first and second derivative
// depends on crse_pkg
`default_nettype none

// One beat in, one beat out: a beat of t_param can be taken on every clock while in_stall
// is low. The pipeline follows the multiply chain t -> t^2 -> t^3 -> A*t^3, where each
// wide product is split into chunks of T_FRAC_BITS+1 bits, multiplied in one stage and
// summed in the next; the seventh stage does the wide add and the last stage the scaling
// shift and the 32-bit saturation. Stalls fill bubbles stage by stage, so in_stall rises
// only when all eight stages hold a beat and the output is held.
// Control points are written over the APB port at byte addresses 0, 8, 16 and 24 and
// may only change while no beat is in flight.
module catmull_rom_segment_eval_top #(
  parameter int COORD_WIDTH   = crse_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS   = crse_pkg::T_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = crse_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,

  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [crse_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  wire logic [crse_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic      [crse_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                                     pready,

  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [T_FRAC_BITS:0]                t_param,

  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    pos_x,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    pos_y,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    pos_z,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    vel_x,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    vel_y,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    vel_z,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    acc_x,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    acc_y,
  output logic signed [crse_pkg::OUT_WIDTH-1:0]    acc_z
);

  import crse_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int TF    = T_FRAC_BITS;
  localparam int WT    = T_FRAC_BITS + 1;
  localparam int T2W   = 2 * WT;
  localparam int T3W   = 3 * WT;
  localparam int CFW   = COORD_WIDTH + 4;
  localparam int PW1   = CFW + WT + 1;
  localparam int AT2W  = CFW + T2W + 1;
  localparam int AT3W  = CFW + T3W + 1;
  localparam int NW    = CFW + T3W + 4;
  localparam int EXW   = NUM_AXES * COORD_WIDTH;
  localparam int NS    = PIPE_STAGES;
  localparam int PRSH  = 3 * T_FRAC_BITS + 1 - OUT_FRAC_BITS;
  localparam int VRSH  = 2 * T_FRAC_BITS + 1 - OUT_FRAC_BITS;
  localparam int ALSH  = (OUT_FRAC_BITS > WT) ? OUT_FRAC_BITS - WT : 0;
  localparam int ARSH  = (WT > OUT_FRAC_BITS) ? WT - OUT_FRAC_BITS : 0;

  // signed coefficient times unsigned chunk
  function automatic logic signed [PW1-1:0] cmul(input logic signed [CFW-1:0] c,
                                                 input logic [WT-1:0] ch);
    cmul = PW1'(c) * PW1'($signed({1'b0, ch}));
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [NW-1:0] v);
    logic [NW-OUT_WIDTH:0] hi;
    hi = v[NW-1:OUT_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      sat_out = v[OUT_WIDTH-1:0];
    end else if (v[NW-1]) begin
      sat_out = {1'b1, {(OUT_WIDTH-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end
  endfunction

  // configuration registers
  logic [CP_REG_BITS-1:0]   cp [NUM_CP];
  logic [CFG_IDX_WIDTH-1:0] cfg_idx;
  logic                     cfg_wr;

  assign cfg_idx = paddr[CFG_ADDR_WIDTH-1:CFG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = {{(CFG_DATA_WIDTH-CP_REG_BITS){1'b0}}, cp[cfg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CP; i++) begin
        cp[i] <= '0;
      end
    end else if (cfg_wr && pready) begin
      cp[cfg_idx] <= pwdata[CP_REG_BITS-1:0];
    end
  end

  // per-axis polynomial coefficients, refreshed every cycle
  logic [EXW-1:0]          cp_ext [NUM_CP];
  logic signed [CFW-1:0]   pe [NUM_CP][NUM_AXES];
  logic signed [CFW-1:0]   coef_a_next [NUM_AXES];
  logic signed [CFW-1:0]   coef_b_next [NUM_AXES];
  logic signed [CFW-1:0]   coef_c_next [NUM_AXES];
  logic signed [CFW-1:0]   coef_d_next [NUM_AXES];
  logic signed [CFW-1:0]   coef_a [NUM_AXES];
  logic signed [CFW-1:0]   coef_b [NUM_AXES];
  logic signed [CFW-1:0]   coef_c [NUM_AXES];
  logic signed [CFW-1:0]   coef_d [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_CP; i++) begin
      cp_ext[i] = EXW'({{EXW{1'b0}}, cp[i]});
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        pe[i][ax] = CFW'($signed(cp_ext[i][ax*CW +: CW]));
      end
    end
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      coef_a_next[ax] = pe[3][ax] - pe[0][ax] + (pe[1][ax] <<< 1) + pe[1][ax]
                        - (pe[2][ax] <<< 1) - pe[2][ax];
      coef_b_next[ax] = (pe[0][ax] <<< 1) - (pe[1][ax] <<< 2) - pe[1][ax]
                        + (pe[2][ax] <<< 2) - pe[3][ax];
      coef_c_next[ax] = pe[2][ax] - pe[0][ax];
      coef_d_next[ax] = pe[1][ax] <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    coef_a <= coef_a_next;
    coef_b <= coef_b_next;
    coef_c <= coef_c_next;
    coef_d <= coef_d_next;
  end

  // pipeline control: a stage loads when it is empty or the next one moves
  logic [NS:1]   vld;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // datapath registers
  logic [WT-1:0]            s1_t;
  logic [WT-1:0]            s2_t;
  logic [T2W-1:0]           s2_t2;
  logic [T2W-1:0]           s3_t3p [2];
  logic signed [PW1-1:0]    s3_at2p [NUM_AXES][2];
  logic signed [PW1-1:0]    s3_bt2p [NUM_AXES][2];
  logic signed [PW1-1:0]    s3_at [NUM_AXES];
  logic signed [PW1-1:0]    s3_bt [NUM_AXES];
  logic signed [PW1-1:0]    s3_ct [NUM_AXES];
  logic [T3W-1:0]           s4_t3;
  logic signed [AT2W-1:0]   s4_at2 [NUM_AXES];
  logic signed [AT2W-1:0]   s4_bt2 [NUM_AXES];
  logic signed [PW1-1:0]    s4_bt [NUM_AXES];
  logic signed [PW1-1:0]    s4_ct [NUM_AXES];
  logic signed [NW-1:0]     s4_accn [NUM_AXES];
  logic signed [PW1-1:0]    s5_at3p [NUM_AXES][3];
  logic signed [NW-1:0]     s5_posr [NUM_AXES];
  logic signed [NW-1:0]     s5_veln [NUM_AXES];
  logic signed [NW-1:0]     s5_accn [NUM_AXES];
  logic signed [AT3W-1:0]   s6_at3 [NUM_AXES];
  logic signed [NW-1:0]     s6_posr [NUM_AXES];
  logic signed [NW-1:0]     s6_veln [NUM_AXES];
  logic signed [NW-1:0]     s6_accn [NUM_AXES];
  logic signed [NW-1:0]     s7_posn [NUM_AXES];
  logic signed [NW-1:0]     s7_veln [NUM_AXES];
  logic signed [NW-1:0]     s7_accn [NUM_AXES];
  logic signed [OUT_WIDTH-1:0] s8_pos [NUM_AXES];
  logic signed [OUT_WIDTH-1:0] s8_vel [NUM_AXES];
  logic signed [OUT_WIDTH-1:0] s8_acc [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_t <= t_param;
    end

    if (rdy[2]) begin
      s2_t  <= s1_t;
      s2_t2 <= T2W'(s1_t) * T2W'(s1_t);
    end

    if (rdy[3]) begin
      for (int j = 0; j < 2; j++) begin
        s3_t3p[j] <= T2W'(s2_t2[j*WT +: WT]) * T2W'(s2_t);
      end
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        for (int j = 0; j < 2; j++) begin
          s3_at2p[ax][j] <= cmul(coef_a[ax], s2_t2[j*WT +: WT]);
          s3_bt2p[ax][j] <= cmul(coef_b[ax], s2_t2[j*WT +: WT]);
        end
        s3_at[ax] <= cmul(coef_a[ax], s2_t);
        s3_bt[ax] <= cmul(coef_b[ax], s2_t);
        s3_ct[ax] <= cmul(coef_c[ax], s2_t);
      end
    end

    if (rdy[4]) begin
      s4_t3 <= T3W'(s3_t3p[0]) + (T3W'(s3_t3p[1]) << WT);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s4_at2[ax]  <= AT2W'(s3_at2p[ax][0]) + (AT2W'(s3_at2p[ax][1]) <<< WT);
        s4_bt2[ax]  <= AT2W'(s3_bt2p[ax][0]) + (AT2W'(s3_bt2p[ax][1]) <<< WT);
        s4_bt[ax]   <= s3_bt[ax];
        s4_ct[ax]   <= s3_ct[ax];
        s4_accn[ax] <= (NW'(s3_at[ax]) <<< 2) + (NW'(s3_at[ax]) <<< 1)
                       + (NW'(coef_b[ax]) <<< WT);
      end
    end

    if (rdy[5]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        for (int j = 0; j < 3; j++) begin
          s5_at3p[ax][j] <= cmul(coef_a[ax], s4_t3[j*WT +: WT]);
        end
        s5_posr[ax] <= (NW'(s4_bt2[ax]) <<< TF) + (NW'(s4_ct[ax]) <<< (2*TF))
                       + (NW'(coef_d[ax]) <<< (3*TF));
        s5_veln[ax] <= (NW'(s4_at2[ax]) <<< 1) + NW'(s4_at2[ax])
                       + (NW'(s4_bt[ax]) <<< WT) + (NW'(coef_c[ax]) <<< (2*TF));
        s5_accn[ax] <= s4_accn[ax];
      end
    end

    if (rdy[6]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s6_at3[ax]  <= AT3W'(s5_at3p[ax][0]) + (AT3W'(s5_at3p[ax][1]) <<< WT)
                       + (AT3W'(s5_at3p[ax][2]) <<< (2*WT));
        s6_posr[ax] <= s5_posr[ax];
        s6_veln[ax] <= s5_veln[ax];
        s6_accn[ax] <= s5_accn[ax];
      end
    end

    if (rdy[7]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s7_posn[ax] <= NW'(s6_at3[ax]) + s6_posr[ax];
        s7_veln[ax] <= s6_veln[ax];
        s7_accn[ax] <= s6_accn[ax];
      end
    end

    if (rdy[8]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s8_pos[ax] <= sat_out(s7_posn[ax] >>> PRSH);
        s8_vel[ax] <= sat_out(s7_veln[ax] >>> VRSH);
        s8_acc[ax] <= sat_out((s7_accn[ax] <<< ALSH) >>> ARSH);
      end
    end
  end

  assign pos_x = s8_pos[0];
  assign pos_y = s8_pos[1];
  assign pos_z = s8_pos[2];
  assign vel_x = s8_vel[0];
  assign vel_y = s8_vel[1];
  assign vel_z = s8_vel[2];
  assign acc_x = s8_acc[0];
  assign acc_y = s8_acc[1];
  assign acc_z = s8_acc[2];

  // input backs up only when every stage is occupied and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_stall))
    else $error("input stalled with a free pipeline stage");

  // a beat in the last inner stage moves to the output once the output frees up
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && !(out_valid && out_stall)) |=> out_valid)
    else $error("beat lost between last stage and output");

  // a taken output with nothing behind it leaves a bubble
  a_bubble: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !vld[NS-1]) |=> !out_valid)
    else $error("output beat repeated");

endmodule

`default_nettype wire

@@ verif/crse_sample_checker.sv @@
// beat checker for catmull_rom_segment_eval_top: snoops the apb port for control points,
// predicts position, velocity and acceleration for every t beat and compares output beats
// depends on crse_pkg
`default_nettype none

module crse_sample_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic                                pready,
  input  wire logic [crse_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  wire logic [crse_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [crse_pkg::T_FRAC_BITS_DEF:0]  t_param,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic [31:0]                         pos_x,
  input  wire logic [31:0]                         pos_y,
  input  wire logic [31:0]                         pos_z,
  input  wire logic [31:0]                         vel_x,
  input  wire logic [31:0]                         vel_y,
  input  wire logic [31:0]                         vel_z,
  input  wire logic [31:0]                         acc_x,
  input  wire logic [31:0]                         acc_y,
  input  wire logic [31:0]                         acc_z,
  output int                                       errors,
  output int                                       pending,
  output int                                       checked
);

  localparam int CW  = crse_pkg::COORD_WIDTH_DEF;
  localparam int TFB = crse_pkg::T_FRAC_BITS_DEF;
  localparam int OFB = crse_pkg::OUT_FRAC_BITS_DEF;
  localparam int HI  = crse_pkg::CFG_ADDR_WIDTH - 1;
  localparam int LO  = crse_pkg::CFG_IDX_LSB;

  typedef struct packed {
    logic [TFB:0]     t;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] acc;
  } segment_sample_t;

  logic [crse_pkg::CP_REG_BITS-1:0] ctrl_pts [crse_pkg::NUM_CP];
  segment_sample_t                  pending_samples [$];
  segment_sample_t                  want_s;
  segment_sample_t                  got_s;
  string                            axis_names = "xyz";

  // floor(num * 2^OFB / 2^shift), clamped to 32 bits
  function automatic logic [31:0] q8_floor_sat(input logic signed [127:0] num,
                                               input int shift);
    logic signed [127:0] v;
    v = (num <<< OFB) >>> shift;
    if (v > 128'sh7fffffff) return 32'h7fffffff;
    if (v < -128'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic segment_sample_t eval_segment(input logic [TFB:0] t);
    logic signed [127:0] tw, s, p0, p1, p2, p3, a, b, c, d;
    segment_sample_t r;
    r.t = t;
    tw  = t;
    s   = 128'sd1 <<< TFB;
    for (int ax = 0; ax < crse_pkg::NUM_AXES; ax++) begin
      p0 = $signed(ctrl_pts[0][ax*CW +: CW]);
      p1 = $signed(ctrl_pts[1][ax*CW +: CW]);
      p2 = $signed(ctrl_pts[2][ax*CW +: CW]);
      p3 = $signed(ctrl_pts[3][ax*CW +: CW]);
      a  = -p0 + 3 * p1 - 3 * p2 + p3;
      b  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c  = p2 - p0;
      d  = 2 * p1;
      r.pos[ax] = q8_floor_sat(a*tw*tw*tw + b*tw*tw*s + c*tw*s*s + d*s*s*s, 3*TFB + 1);
      r.vel[ax] = q8_floor_sat(3*a*tw*tw + 2*b*tw*s + c*s*s, 2*TFB + 1);
      r.acc[ax] = q8_floor_sat(6*a*tw + 2*b*s, TFB + 1);
    end
    return r;
  endfunction

  task automatic note_miss(input string what, input int ax, input logic [31:0] want,
                           input logic [31:0] got, input logic [TFB:0] t);
    errors++;
    if (errors <= 10)
      $display("mismatch %s_%c t=%0d: expected %0d got %0d", what, axis_names[ax], t,
               $signed(want), $signed(got));
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < crse_pkg::NUM_CP; i++) ctrl_pts[i] = '0;
      pending_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        ctrl_pts[paddr[HI:LO]] = pwdata[crse_pkg::CP_REG_BITS-1:0];
      if (out_valid && !out_stall) begin
        got_s.pos = {pos_z, pos_y, pos_x};
        got_s.vel = {vel_z, vel_y, vel_x};
        got_s.acc = {acc_z, acc_y, acc_x};
        if (pending_samples.size() == 0) begin
          errors++;
          if (errors <= 10) $display("output beat with no sample pending");
        end else begin
          want_s = pending_samples.pop_front();
          checked++;
          for (int ax = 0; ax < crse_pkg::NUM_AXES; ax++) begin
            if (got_s.pos[ax] !== want_s.pos[ax])
              note_miss("pos", ax, want_s.pos[ax], got_s.pos[ax], want_s.t);
            if (got_s.vel[ax] !== want_s.vel[ax])
              note_miss("vel", ax, want_s.vel[ax], got_s.vel[ax], want_s.t);
            if (got_s.acc[ax] !== want_s.acc[ax])
              note_miss("acc", ax, want_s.acc[ax], got_s.acc[ax], want_s.t);
          end
        end
      end
      if (in_valid && !in_stall) pending_samples.push_back(eval_segment(t_param));
    end
    pending <= pending_samples.size();
  end

endmodule

`default_nettype wire

@@ verif/tb_catmull_rom_segment_eval_top.sv @@
// testbench top for catmull_rom_segment_eval_top: drives t beats in bursts, stalls the
// output, rewrites control points between phases and reports the verdict
// depends on crse_pkg, catmull_rom_segment_eval_top and crse_sample_checker
`default_nettype none

module tb_catmull_rom_segment_eval_top;

  localparam int TW        = crse_pkg::T_FRAC_BITS_DEF + 1;
  localparam int AW        = crse_pkg::CFG_ADDR_WIDTH;
  localparam int DW        = crse_pkg::CFG_DATA_WIDTH;
  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 80;
  localparam int NUM_PHASE = 12;

  typedef enum int {CP_0 = 0, CP_1 = 1, CP_2 = 2, CP_3 = 3} cp_index_e;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          psel      = 1'b0;
  logic          penable   = 1'b0;
  logic          pwrite    = 1'b0;
  logic [AW-1:0] paddr     = '0;
  logic [DW-1:0] pwdata    = '0;
  logic [DW-1:0] prdata;
  logic          pready;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  logic [TW-1:0] t_param   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [31:0]   pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;

  int errors, pending, checked;
  int beats_sent = 0;
  int cp_sets    = 0;
  int hold_asks  = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_pct  = 0;
  int mode_left  = 0;

  always #1 clk = ~clk;

  catmull_rom_segment_eval_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .t_param(t_param),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z)
  );

  crse_sample_checker sample_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .t_param(t_param),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .errors(errors), .pending(pending), .checked(checked)
  );

  // receiver: long hold-offs on request, otherwise stretches of random stall density
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_asks) begin
      hold_seen++;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("tb_catmull_rom_segment_eval_top failed");
    $finish;
  end

  task automatic apb_write(input cp_index_e idx, input logic [DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(int'(idx) << crse_pkg::CFG_IDX_LSB);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic [TW-1:0] tv);
    in_valid <= 1'b1;
    t_param  <= tv;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  function automatic logic [TW-1:0] pick_t();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return TW'($urandom_range(0, 65536));
      6, 7:             return TW'($urandom_range(0, (1 << TW) - 1));
      8: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return TW'(65536);
          2:       return TW'(65535);
          3:       return TW'(1);
          default: return '1;
        endcase
      end
      default:          return TW'($urandom_range(0, 64) + ($urandom_range(0, 1) ? 65472 : 0));
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DW-1:0] phase_cp(input int p, input int idx);
    logic [15:0] hi, lo;
    hi = 16'h7fff;
    lo = 16'h8000;
    case (p)
      1:       return idx % 2 ? {16'h0, hi, hi, hi} : {16'h0, lo, lo, lo};
      2:       return idx % 2 ? {16'h0, lo, lo, lo} : {16'h0, hi, hi, hi};
      3:       return {16'hffff, hi, hi, hi};
      4:       return {16'hffff, lo, lo, lo};
      default: return {16'($urandom), pick_coord(), pick_coord(), pick_coord()};
    endcase
  endfunction

  // random t beats in bursts; hold_at < 0 means no long output hold-off
  task automatic stream_t(input int n, input int hold_at);
    int burst, gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_asks++;
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0 && i > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      send_beat(pick_t());
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [TW-1:0] corner_t [15];
    corner_t = '{17'd0, 17'd1, 17'd2, 17'd16384, 17'd32768, 17'd49152, 17'd65535,
                 17'd65536, 17'd65537, 17'd98304, 17'd131071, 17'h0aaaa, 17'h15555,
                 17'h10000, 17'h0ffff};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // control points still at their reset value
    send_beat('0);
    send_beat(TW'(65536));
    send_beat('1);
    in_valid <= 1'b0;
    drain();

    for (int p = 1; p <= NUM_PHASE; p++) begin
      apb_write(CP_0, phase_cp(p, 0));
      apb_write(CP_1, phase_cp(p, 1));
      apb_write(CP_2, phase_cp(p, 2));
      apb_write(CP_3, phase_cp(p, 3));
      cp_sets++;
      if (p == 1) begin
        foreach (corner_t[i]) send_beat(corner_t[i]);
        in_valid <= 1'b0;
        @(posedge clk);
      end
      if (p <= 4) stream_t(60, p == 3 ? 20 : -1);
      else        stream_t(170, p == 8 ? 50 : -1);
      drain();
    end

    repeat (40) @(posedge clk);
    $display("%0d t beats sent over %0d control point sets, %0d results compared", beats_sent,
             cp_sets, checked);
    $display("t covered 0 to just under 2.0, extreme and random control points, long output holds");
    if (errors == 0 && pending == 0)
      $display("tb_catmull_rom_segment_eval_top passed");
    else
      $display("tb_catmull_rom_segment_eval_top failed");
    $finish;
  end

endmodule

`default_nettype wire
